### rtl/mctt_pkg.sv
// Package for the multi-channel tick timer: payload structs, request codes,
// controller states and command/status bundles. No dependencies.
package mctt_pkg;

    localparam int DEF_NUM_CHANNELS = 16;
    localparam int DEF_MAX_ACTIVE   = 10;

    localparam int CH_W       = 4;
    localparam int PERIOD_W   = 32;
    localparam int MAX_RES    = 16;
    localparam int RES_CNT_W  = 5;

    localparam logic [1:0] REQ_CONFIG = 2'd0;
    localparam logic [1:0] REQ_START  = 2'd1;
    localparam logic [1:0] REQ_STOP   = 2'd2;
    localparam logic [1:0] REQ_TICK   = 2'd3;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [CH_W-1:0]     channel;
        logic [PERIOD_W-1:0] period;
        logic                reload_mode;
        logic                notify_enable;
    } t_in;

    typedef struct packed {
        logic [CH_W-1:0] result_channel;
        logic            expired;
        logic            accepted;
        logic            last;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PERIOD_RD,
        ST_RESP,
        ST_WALK,
        ST_FLUSH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the request, clear the walk state
        logic period_rd;   // read the addressed channel's period
        logic resp;        // apply configure/start/stop and load its result
        logic walk_step;   // advance the channel walk by one position
        logic flush;       // emit the held expiry as the final result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
        logic walk_hold;   // walk must pause until the output drains
        logic walk_done;   // every channel read has been issued
        logic pend_valid;  // an expiry is held back for its last flag
    } t_status;

endpackage

### rtl/mctt_datapath.sv
// Datapath of the multi-channel tick timer: channel memories, flags, walk
// pipeline and output register. Depends on mctt_pkg.
module mctt_datapath #(
    parameter int NUM_CHANNELS = mctt_pkg::DEF_NUM_CHANNELS,
    parameter int MAX_ACTIVE   = mctt_pkg::DEF_MAX_ACTIVE
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mctt_pkg::t_in    i_in_data,
    input  mctt_pkg::t_cmd   i_cmd,
    output mctt_pkg::t_status o_status,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output mctt_pkg::t_out   o_out_data
);

    localparam int ChW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int IdxW = $clog2(NUM_CHANNELS + 1);
    localparam int CntW = IdxW;
    localparam int PW   = mctt_pkg::PERIOD_W;
    localparam int RW   = mctt_pkg::RES_CNT_W;

    mctt_pkg::t_in          r_req;
    logic [NUM_CHANNELS-1:0] r_active;
    logic [NUM_CHANNELS-1:0] r_reload;
    logic [NUM_CHANNELS-1:0] r_notify;
    logic [NUM_CHANNELS-1:0] r_valid;
    logic [CntW-1:0]        r_count;

    logic [PW-1:0]          r_per_mem [NUM_CHANNELS];
    logic [PW-1:0]          r_rem_mem [NUM_CHANNELS];
    logic [PW-1:0]          r_per_rd;
    logic [PW-1:0]          r_rem_rd;
    logic                   r_rd_valid;

    logic [IdxW-1:0]        r_idx;
    logic                   r_proc_v;
    logic [ChW-1:0]         r_proc_idx;
    logic                   r_pend_v;
    logic [ChW-1:0]         r_pend_idx;
    logic [RW-1:0]          r_res_cnt;

    logic                   r_out_v;
    mctt_pkg::t_out         r_out;

    logic                   ch_ok;
    logic [ChW-1:0]         req_idx;
    logic                   req_act;
    logic                   acc;
    logic [PW-1:0]          per_val;
    logic [PW-1:0]          rem_val;
    logic [PW-1:0]          rem_dec;
    logic                   walk_rd;
    logic [ChW-1:0]         walk_idx;
    logic                   proc_live;
    logic                   proc_zero;
    logic                   exp_rep;
    logic                   out_free;
    logic                   proc_fire;
    logic                   push_mid;
    logic                   rd_en;
    logic [ChW-1:0]         rd_addr;
    logic                   rem_we;
    logic [ChW-1:0]         rem_wa;
    logic [PW-1:0]          rem_wd;
    logic                   per_we;

    always_comb begin
        ch_ok    = 32'(r_req.channel) < 32'(NUM_CHANNELS);
        req_idx  = ChW'(r_req.channel);
        req_act  = ch_ok && r_active[req_idx];
        case (r_req.req_type)
            mctt_pkg::REQ_CONFIG: acc = ch_ok && !req_act;
            mctt_pkg::REQ_START:  acc = ch_ok && !req_act
                                        && (32'(r_count) < 32'(MAX_ACTIVE));
            mctt_pkg::REQ_STOP:   acc = req_act;
            default:              acc = 1'b0;
        endcase

        // An entry never written since reset reads as zero.
        per_val  = r_rd_valid ? r_per_rd : '0;
        rem_val  = r_rd_valid ? r_rem_rd : '0;
        rem_dec  = rem_val - PW'(1);

        walk_rd  = r_idx < IdxW'(NUM_CHANNELS);
        walk_idx = ChW'(r_idx);

        proc_live = r_proc_v && r_active[r_proc_idx] && (rem_val != '0);
        proc_zero = proc_live && (rem_dec == '0);
        exp_rep   = proc_zero && r_notify[r_proc_idx]
                    && (r_res_cnt < RW'(mctt_pkg::MAX_RES));

        out_free  = !r_out_v || !i_out_stall;
        proc_fire = i_cmd.walk_step && r_proc_v;
        push_mid  = proc_fire && exp_rep && r_pend_v;

        rd_en   = i_cmd.period_rd || (i_cmd.walk_step && walk_rd);
        rd_addr = i_cmd.period_rd ? req_idx : walk_idx;

        per_we = i_cmd.resp && acc && (r_req.req_type == mctt_pkg::REQ_CONFIG);
        rem_we = 1'b0;
        rem_wa = req_idx;
        rem_wd = r_req.period;
        if (i_cmd.resp && acc && (r_req.req_type == mctt_pkg::REQ_CONFIG)) begin
            rem_we = 1'b1;
        end else if (i_cmd.resp && acc && (r_req.req_type == mctt_pkg::REQ_START)) begin
            rem_we = 1'b1;
            rem_wd = per_val;
        end else if (proc_fire && proc_live) begin
            rem_we = 1'b1;
            rem_wa = r_proc_idx;
            if (proc_zero) begin
                rem_wd = r_reload[r_proc_idx] ? per_val : '0;
            end else begin
                rem_wd = rem_dec;
            end
        end

        o_status.out_free   = out_free;
        o_status.walk_hold  = r_proc_v && exp_rep && r_pend_v && !out_free;
        o_status.walk_done  = !walk_rd;
        o_status.pend_valid = r_pend_v;
    end

    // Channel memories, one write and one read per cycle each.
    always_ff @(posedge i_clk) begin
        if (per_we) begin
            r_per_mem[req_idx] <= r_req.period;
        end
        if (rem_we) begin
            r_rem_mem[rem_wa] <= rem_wd;
        end
        if (rd_en) begin
            r_per_rd   <= r_per_mem[rd_addr];
            r_rem_rd   <= r_rem_mem[rd_addr];
            r_rd_valid <= r_valid[rd_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_in_data;
        end
        if (i_cmd.walk_step) begin
            r_proc_idx <= walk_idx;
        end
        if (proc_fire && exp_rep) begin
            r_pend_idx <= r_proc_idx;
        end
        if (i_cmd.resp) begin
            r_out.result_channel <= r_req.channel;
            r_out.expired        <= 1'b0;
            r_out.accepted       <= acc;
            r_out.last           <= 1'b1;
        end else if (push_mid || i_cmd.flush) begin
            r_out.result_channel <= mctt_pkg::CH_W'(r_pend_idx);
            r_out.expired        <= 1'b1;
            r_out.accepted       <= 1'b0;
            r_out.last           <= i_cmd.flush;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_reload  <= '0;
            r_notify  <= '0;
            r_valid   <= '0;
            r_count   <= '0;
            r_idx     <= '0;
            r_proc_v  <= 1'b0;
            r_pend_v  <= 1'b0;
            r_res_cnt <= '0;
            r_out_v   <= 1'b0;
        end else begin
            if (i_cmd.resp && acc) begin
                case (r_req.req_type)
                    mctt_pkg::REQ_CONFIG: begin
                        r_reload[req_idx] <= r_req.reload_mode;
                        r_notify[req_idx] <= r_req.notify_enable;
                        r_valid[req_idx]  <= 1'b1;
                    end
                    mctt_pkg::REQ_START: begin
                        r_active[req_idx] <= 1'b1;
                        r_count           <= r_count + CntW'(1);
                    end
                    mctt_pkg::REQ_STOP: begin
                        r_active[req_idx] <= 1'b0;
                        if (r_count != '0) begin
                            r_count <= r_count - CntW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (proc_fire && proc_zero && !r_reload[r_proc_idx]) begin
                r_active[r_proc_idx] <= 1'b0;
                if (r_count != '0) begin
                    r_count <= r_count - CntW'(1);
                end
            end

            if (i_cmd.capture) begin
                r_idx     <= '0;
                r_proc_v  <= 1'b0;
                r_pend_v  <= 1'b0;
                r_res_cnt <= '0;
            end else begin
                if (i_cmd.walk_step) begin
                    r_proc_v <= walk_rd;
                    if (walk_rd) begin
                        r_idx <= r_idx + IdxW'(1);
                    end
                end
                if (proc_fire && exp_rep) begin
                    r_pend_v  <= 1'b1;
                    r_res_cnt <= r_res_cnt + RW'(1);
                end else if (i_cmd.flush) begin
                    r_pend_v <= 1'b0;
                end
            end

            if (i_cmd.resp || push_mid || i_cmd.flush) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

### rtl/mctt_ctrl.sv
// Controller state machine of the multi-channel tick timer. Sequences each
// request through the datapath by commands. Depends on mctt_pkg.
module mctt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_req_type,
    output logic              o_in_stall,
    input  mctt_pkg::t_status i_status,
    output mctt_pkg::t_cmd    o_cmd
);

    mctt_pkg::t_state r_state;
    mctt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mctt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            mctt_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    case (i_req_type)
                        mctt_pkg::REQ_TICK:  n_state = mctt_pkg::ST_WALK;
                        mctt_pkg::REQ_START: n_state = mctt_pkg::ST_PERIOD_RD;
                        default:             n_state = mctt_pkg::ST_RESP;
                    endcase
                end
            end
            mctt_pkg::ST_PERIOD_RD: begin
                o_cmd.period_rd = 1'b1;
                n_state         = mctt_pkg::ST_RESP;
            end
            mctt_pkg::ST_RESP: begin
                if (i_status.out_free) begin
                    o_cmd.resp = 1'b1;
                    n_state    = mctt_pkg::ST_IDLE;
                end
            end
            mctt_pkg::ST_WALK: begin
                if (!i_status.walk_hold) begin
                    o_cmd.walk_step = 1'b1;
                    if (i_status.walk_done) begin
                        n_state = mctt_pkg::ST_FLUSH;
                    end
                end
            end
            mctt_pkg::ST_FLUSH: begin
                if (!i_status.pend_valid) begin
                    n_state = mctt_pkg::ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = mctt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mctt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/multi_channel_tick_timer.sv
// Multi-channel tick timer: a bank of countdown channels with one-shot or
// auto-reload behavior. Top level; instantiates mctt_ctrl and mctt_datapath
// and uses mctt_pkg.
//
// Usage: requests arrive on the input channel (i_in_valid, o_in_stall,
// i_in_data). A configure, start or stop produces exactly one result on the
// output channel (o_out_valid, i_out_stall, o_out_data) carrying the
// addressed channel and whether the request took effect. A tick produces one
// result per reported expiry, in ascending channel order, with last set on
// the final one; a tick with no reported expiry produces no transfer at all.
// Configure and stop pass through a response state before the next possible
// input transfer; start first passes through a state for the period memory read.
// A tick walks every channel through the memory read port, one channel per
// cycle while the walk is not paused by a stalled output.
// Results are held in an output register, so a request is taken while the
// previous result still waits. When the receiver stalls, a pending result
// stays put; the walk pauses only when a second expiry must leave before the
// held one has drained, and a single result waits in its own state.
// Reset is synchronous and active low: all channels become inactive and
// unconfigured (periods and counts read as zero), the active count clears and
// the output register empties. No clearing pass is needed after reset.
module multi_channel_tick_timer #(
    parameter int NUM_CHANNELS = mctt_pkg::DEF_NUM_CHANNELS,
    parameter int MAX_ACTIVE   = mctt_pkg::DEF_MAX_ACTIVE
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mctt_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output mctt_pkg::t_out o_out_data
);

    // Commands and status between the state machine and the datapath.
    mctt_pkg::t_cmd    cmd;
    mctt_pkg::t_status status;

    mctt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_data.req_type),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mctt_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .MAX_ACTIVE   (MAX_ACTIVE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/mctt_checker.sv
// Port-level checker for the multi-channel tick timer, bound to the top
// level. Depends on mctt_pkg.
module mctt_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input mctt_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input mctt_pkg::t_out o_out_data
);

    // A stalled result stays and does not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // Reset empties the output register.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Every request is worked on alone: the input stalls after a transfer.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken on consecutive cycles");

    // A non-final expiry means its tick is still in progress.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> o_in_stall && o_out_data.expired)
        else $error("non-final result while input is open");

endmodule

bind multi_channel_tick_timer mctt_checker u_mctt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

### tb/tb_multi_channel_tick_timer.sv
`timescale 1ns / 1ps
// Self-checking testbench for multi_channel_tick_timer: directed and random
// requests, a built-in timer bank predictor and an in-order result checker.
// Depends on mctt_pkg and the multi_channel_tick_timer RTL.
module tb_multi_channel_tick_timer;

    localparam int NUM_CH      = mctt_pkg::DEF_NUM_CHANNELS;
    localparam int ACTIVE_CAP  = mctt_pkg::DEF_MAX_ACTIVE;
    localparam int N_RANDOM    = 430;
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 400;

    // One slot of pending stimulus. A drain pause holds the sender back
    // until every expected result has arrived.
    typedef struct {
        logic          pause_for_drain;
        mctt_pkg::t_in req;
    } t_req_slot;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    mctt_pkg::t_in  i_in_data   = '0;
    logic           i_out_stall = 1'b0;
    logic           o_in_stall;
    logic           o_out_valid;
    mctt_pkg::t_out o_out_data;

    t_req_slot      req_q[$];
    mctt_pkg::t_out exp_results[$];

    // Private copy of the timer bank state.
    logic [31:0] period_mem[NUM_CH];
    logic [31:0] remain_mem[NUM_CH];
    logic        reload_on[NUM_CH];
    logic        notify_on[NUM_CH];
    logic        armed[NUM_CH];
    int          armed_count = 0;

    int n_total_reqs = 0;
    int n_offered    = 0;
    int n_taken      = 0;
    int err_cnt      = 0;
    int cycle_cnt    = 0;

    multi_channel_tick_timer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one accepted request to the private bank state and appends the
    // results it should cause to exp_results.
    function automatic void predict_timer_results(input mctt_pkg::t_in req);
        mctt_pkg::t_out res;
        int   first;
        int   n_exp;
        int   ch;
        first = exp_results.size();
        n_exp = 0;
        ch    = int'(req.channel);
        res   = '0;
        if (req.req_type == mctt_pkg::REQ_TICK) begin
            // Walk the bank in ascending order; a zero count never moves.
            for (int i = 0; i < NUM_CH; i++) begin
                if (armed[i] && remain_mem[i] != 32'd0) begin
                    remain_mem[i] = remain_mem[i] - 32'd1;
                    if (remain_mem[i] == 32'd0) begin
                        if (notify_on[i] && n_exp < mctt_pkg::MAX_RES) begin
                            res.result_channel = i[mctt_pkg::CH_W-1:0];
                            res.expired        = 1'b1;
                            res.accepted       = 1'b0;
                            res.last           = 1'b0;
                            exp_results.push_back(res);
                            n_exp++;
                        end
                        if (reload_on[i]) begin
                            remain_mem[i] = period_mem[i];
                        end else begin
                            armed[i] = 1'b0;
                            if (armed_count > 0) armed_count--;
                        end
                    end
                end
            end
            if (n_exp > 0) exp_results[first + n_exp - 1].last = 1'b1;
        end else begin
            res.result_channel = req.channel;
            res.expired        = 1'b0;
            res.accepted       = 1'b0;
            res.last           = 1'b1;
            if (ch < NUM_CH) begin
                case (req.req_type)
                    mctt_pkg::REQ_CONFIG: begin
                        if (!armed[ch]) begin
                            period_mem[ch] = req.period;
                            remain_mem[ch] = req.period;
                            reload_on[ch]  = req.reload_mode;
                            notify_on[ch]  = req.notify_enable;
                            res.accepted   = 1'b1;
                        end
                    end
                    mctt_pkg::REQ_START: begin
                        if (!armed[ch] && armed_count < ACTIVE_CAP) begin
                            armed[ch]      = 1'b1;
                            remain_mem[ch] = period_mem[ch];
                            armed_count++;
                            res.accepted   = 1'b1;
                        end
                    end
                    default: begin
                        if (armed[ch]) begin
                            armed[ch] = 1'b0;
                            if (armed_count > 0) armed_count--;
                            res.accepted = 1'b1;
                        end
                    end
                endcase
            end
            exp_results.push_back(res);
        end
    endfunction

    task automatic queue_req(input logic [1:0] kind, input int ch, input logic [31:0] per,
                             input logic rel, input logic ntf);
        t_req_slot slot;
        slot.pause_for_drain   = 1'b0;
        slot.req.req_type      = kind;
        slot.req.channel       = ch[mctt_pkg::CH_W-1:0];
        slot.req.period        = per;
        slot.req.reload_mode   = rel;
        slot.req.notify_enable = ntf;
        req_q.push_back(slot);
        n_total_reqs++;
    endtask

    task automatic queue_drain_pause();
        t_req_slot slot;
        slot.pause_for_drain = 1'b1;
        slot.req             = '0;
        req_q.push_back(slot);
    endtask

    // Every transfer on the input side is counted and fed to the predictor
    // here, in the same edge the block takes it. The cycle counter also
    // guards the run against a hang.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t ns: timeout after %0d cycles", $time, cycle_cnt);
            $display("RESULT: ERROR");
            $finish;
        end else if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_timer_results(i_in_data);
            n_taken++;
        end
    end

    // Request driver. A request stays on the bus, unchanged, until its
    // transfer; idle gaps come in random bursts, with calm stretches and
    // none at all near the end of the run.
    int send_gap  = 0;
    int send_calm = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || n_taken == n_offered) begin
            if (send_gap != 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (req_q.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (req_q[0].pause_for_drain) begin
                // Hold off until everything already sent has been answered.
                i_in_valid <= 1'b0;
                if (n_taken == n_offered && exp_results.size() == 0) begin
                    void'(req_q.pop_front());
                end
            end else if (n_taken + 50 < n_total_reqs && send_calm == 0 &&
                         $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(1, 15) - 1;
                i_in_valid <= 1'b0;
            end else begin
                if (send_calm != 0) begin
                    send_calm--;
                end else if ($urandom_range(0, 19) == 0) begin
                    send_calm = $urandom_range(30, 100);
                end
                i_in_valid <= 1'b1;
                i_in_data  <= req_q[0].req;
                void'(req_q.pop_front());
                n_offered++;
            end
        end
    end

    // Result-side stall. Bursts of stall and of free cycles alternate at
    // random. Once, the receiver holds off long enough for the block to fill
    // up and push back on its input.
    int  hold_left      = 0;
    int  rcv_burst      = 0;
    logic rcv_mode      = 1'b0;
    logic long_hold_done = 1'b0;

    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!long_hold_done && n_taken >= 120) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else if (n_taken + 50 >= n_total_reqs && n_total_reqs != 0) begin
            i_out_stall <= 1'b0;
        end else if (rcv_burst != 0) begin
            rcv_burst--;
            i_out_stall <= rcv_mode;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: begin
                    rcv_mode  = 1'b1;
                    rcv_burst = $urandom_range(1, 15) - 1;
                end
                19: begin
                    rcv_mode  = 1'b0;
                    rcv_burst = $urandom_range(30, 100);
                end
                default: begin
                    rcv_mode  = 1'b0;
                    rcv_burst = $urandom_range(1, 15) - 1;
                end
            endcase
            i_out_stall <= rcv_mode;
        end
    end

    // Result checker: every result transfer must match the oldest expected
    // result, field by field.
    always @(posedge i_clk) begin : result_check
        mctt_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_results.size() == 0) begin
                if (err_cnt < 40) begin
                    $display("%0t ns: unexpected result, expected none, ", $time,
                             "got ch=%0d exp=%0b acc=%0b last=%0b",
                             o_out_data.result_channel, o_out_data.expired,
                             o_out_data.accepted, o_out_data.last);
                end
                err_cnt++;
            end else begin
                want = exp_results.pop_front();
                if (o_out_data.result_channel !== want.result_channel ||
                    o_out_data.expired !== want.expired ||
                    o_out_data.accepted !== want.accepted ||
                    o_out_data.last !== want.last) begin
                    if (err_cnt < 40) begin
                        $display("%0t ns: mismatch, ", $time,
                                 "expected ch=%0d exp=%0b acc=%0b last=%0b, ",
                                 want.result_channel, want.expired, want.accepted,
                                 want.last,
                                 "got ch=%0d exp=%0b acc=%0b last=%0b",
                                 o_out_data.result_channel, o_out_data.expired,
                                 o_out_data.accepted, o_out_data.last);
                    end
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        logic [1:0]  kind;
        logic [31:0] per;
        int          pick;

        for (int i = 0; i < NUM_CH; i++) begin
            period_mem[i] = '0;
            remain_mem[i] = '0;
            reload_on[i]  = 1'b0;
            notify_on[i]  = 1'b0;
            armed[i]      = 1'b0;
        end

        // Directed part. One-shot with notify, largest period with reload,
        // zero period, a silent one-shot and a short auto-reload channel.
        queue_req(mctt_pkg::REQ_CONFIG, 0, 32'd1, 1'b0, 1'b1);
        queue_req(mctt_pkg::REQ_CONFIG, 15, 32'hFFFF_FFFF, 1'b1, 1'b1);
        queue_req(mctt_pkg::REQ_CONFIG, 1, 32'd0, 1'b1, 1'b1);
        queue_req(mctt_pkg::REQ_CONFIG, 2, 32'd2, 1'b1, 1'b1);
        queue_req(mctt_pkg::REQ_CONFIG, 3, 32'd1, 1'b0, 1'b0);
        queue_req(mctt_pkg::REQ_START, 0, '0, 1'b0, 1'b0);
        queue_req(mctt_pkg::REQ_START, 1, '0, 1'b0, 1'b0);
        queue_req(mctt_pkg::REQ_START, 2, '0, 1'b0, 1'b0);
        queue_req(mctt_pkg::REQ_START, 3, '0, 1'b0, 1'b0);
        queue_req(mctt_pkg::REQ_START, 15, '0, 1'b0, 1'b0);
        // Configure and start of a channel that is already running are refused.
        queue_req(mctt_pkg::REQ_CONFIG, 0, 32'd7, 1'b1, 1'b0);
        queue_req(mctt_pkg::REQ_START, 0, '0, 1'b0, 1'b0);
        // First tick fires channel 0 and retires channel 3 silently; the
        // second one fires channel 2, which reloads.
        queue_req(mctt_pkg::REQ_TICK, 9, 32'hA5A5_A5A5, 1'b1, 1'b1);
        queue_req(mctt_pkg::REQ_TICK, 6, 32'h5A5A_5A5A, 1'b0, 1'b0);
        // Stop of a running channel, then of the same channel and of one that
        // never ran.
        queue_req(mctt_pkg::REQ_STOP, 2, '0, 1'b0, 1'b0);
        queue_req(mctt_pkg::REQ_STOP, 2, '0, 1'b0, 1'b0);
        queue_req(mctt_pkg::REQ_STOP, 5, '1, 1'b1, 1'b1);
        // Fill the bank up to the active limit; the last start is refused.
        for (int c = 4; c <= 12; c++) begin
            queue_req(mctt_pkg::REQ_START, c, '0, 1'b0, 1'b0);
        end
        queue_drain_pause();

        // Random part: short periods so that expiries are frequent, with the
        // odd zero or very long period, and stops to free active slots.
        for (int k = 0; k < N_RANDOM; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 20)      kind = mctt_pkg::REQ_CONFIG;
            else if (pick < 40) kind = mctt_pkg::REQ_START;
            else if (pick < 55) kind = mctt_pkg::REQ_STOP;
            else                kind = mctt_pkg::REQ_TICK;
            case ($urandom_range(0, 15))
                0:       per = 32'd0;
                1:       per = $urandom;
                2:       per = 32'hFFFF_FFFF;
                default: per = $urandom_range(1, 6);
            endcase
            queue_req(kind, $urandom_range(0, NUM_CH - 1), per, 1'($urandom_range(0, 1)),
                      $urandom_range(0, 3) != 0);
            if (k == 200) queue_drain_pause();
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_taken < n_total_reqs || exp_results.size() != 0) begin
            @(posedge i_clk);
        end
        // Let a tick walk run out in case a stray result would follow.
        repeat (NUM_CH + 8) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
